// ----- src/utf8iv_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8iv_pkg
// Shared types and constants for the UTF-8 identifier validator.
// ----------------------------------------------------------------------------
package utf8iv_pkg;

  // Width of the internal length counter (saturating).
  localparam int unsigned CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [15:0] MaxBytesReset = 16'd4096;
  localparam logic [31:0] ShowMax       = 32'd65535;
  localparam logic [31:0] NameMaxBytes  = 32'd255;

  // Lead and continuation byte boundaries.
  localparam logic [7:0] LeadTwoLo   = 8'hC2;
  localparam logic [7:0] LeadTwoHi   = 8'hDF;
  localparam logic [7:0] LeadThreeLo = 8'hE0;
  localparam logic [7:0] LeadThreeHi = 8'hEF;
  localparam logic [7:0] LeadFourLo  = 8'hF0;
  localparam logic [7:0] LeadFourHi  = 8'hF4;
  localparam logic [7:0] LeadSurr    = 8'hED;
  localparam logic [7:0] ContA0      = 8'hA0;
  localparam logic [7:0] Cont90      = 8'h90;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;

  // Range rule applied to the continuation byte that follows a lead.
  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_GE_A0,
    RULE_LT_A0,
    RULE_GE_90,
    RULE_LT_90
  } rule_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        string_valid;
    logic        identifier_valid;
    logic [15:0] byte_count;
  } result_t;

endpackage

// ----- src/utf8iv_in_stage.sv -----
// ----------------------------------------------------------------------------
// utf8iv_in_stage
// Input register for incoming bytes with valid/stall handshake.
// ----------------------------------------------------------------------------
module utf8iv_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  utf8iv_pkg::item_t   in_item,
  input  logic                advance,
  output logic                item_valid,
  output utf8iv_pkg::item_t   item
);
  import utf8iv_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // The held byte leaves in the same cycle a new one may arrive.
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- src/utf8iv_core.sv -----
// ----------------------------------------------------------------------------
// utf8iv_core
// Per-string checking state and the byte-by-byte UTF-8 and name rules.
// ----------------------------------------------------------------------------
module utf8iv_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 advance,
  input  utf8iv_pkg::item_t    item,
  output logic                 res_load,
  output utf8iv_pkg::result_t  res
);
  import utf8iv_pkg::*;

  logic [15:0]          max_bytes_r;
  logic [1:0]           pend_r, pend_nxt;
  rule_t                rule_r, rule_nxt;
  logic [CountBits-1:0] cnt_r, cnt_nxt;
  logic                 text_err_r, text_err_nxt;
  logic                 name_err_r, name_err_nxt;
  logic                 first_r, first_nxt;
  logic [7:0]           b;
  logic                 name_start, name_more;
  logic [31:0]          cnt_wide;
  logic                 str_ok;

  assign b = item.byte_value;

  always_comb begin
    name_start = (b inside {8'h5F, [8'h41:8'h5A], [8'h61:8'h7A]});
    name_more  = name_start || (b inside {[8'h30:8'h39]});
  end

  always_comb begin
    pend_nxt     = pend_r;
    rule_nxt     = rule_r;
    text_err_nxt = text_err_r;
    name_err_nxt = name_err_r;
    first_nxt    = first_r;
    cnt_nxt      = (cnt_r == CountMax) ? cnt_r : cnt_r + CountBits'(1);

    if (pend_r == 2'd0) begin
      if (!b[7]) begin
        if (b == 8'h00) begin
          text_err_nxt = 1'b1;
        end
        if (first_r ? !name_start : !name_more) begin
          name_err_nxt = 1'b1;
        end
      end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
        pend_nxt = 2'd1;
        rule_nxt = RULE_NONE;
      end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
        pend_nxt = 2'd2;
        rule_nxt = (b == LeadThreeLo) ? RULE_GE_A0 :
                   (b == LeadSurr)    ? RULE_LT_A0 : RULE_NONE;
      end else if (b >= LeadFourLo && b <= LeadFourHi) begin
        pend_nxt = 2'd3;
        rule_nxt = (b == LeadFourLo) ? RULE_GE_90 :
                   (b == LeadFourHi) ? RULE_LT_90 : RULE_NONE;
      end else begin
        text_err_nxt = 1'b1;
      end
      first_nxt = 1'b0;
    end else if ((b & ContMask) != ContTag) begin
      // A missing continuation drops the sequence; the byte is not a new lead.
      text_err_nxt = 1'b1;
      pend_nxt     = 2'd0;
      rule_nxt     = RULE_NONE;
    end else begin
      case (rule_r)
        RULE_GE_A0: if (b <  ContA0) text_err_nxt = 1'b1;
        RULE_LT_A0: if (b >= ContA0) text_err_nxt = 1'b1;
        RULE_GE_90: if (b <  Cont90) text_err_nxt = 1'b1;
        RULE_LT_90: if (b >= Cont90) text_err_nxt = 1'b1;
        default: ;
      endcase
      rule_nxt = RULE_NONE;
      pend_nxt = pend_r - 2'd1;
    end
  end

  assign cnt_wide = 32'(cnt_nxt);
  assign str_ok   = !text_err_nxt && (pend_nxt == 2'd0) && (cnt_nxt != '0) &&
                    (cnt_wide <= 32'(max_bytes_r));

  assign res_load             = advance && item.last_byte;
  assign res.string_valid     = str_ok;
  assign res.identifier_valid = str_ok && !name_err_nxt && (cnt_wide <= NameMaxBytes);
  assign res.byte_count       = (cnt_wide > ShowMax) ? 16'hFFFF : cnt_wide[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MaxBytesReset;
    end else if (cfg_wr_en) begin
      max_bytes_r <= cfg_wr_data;
    end
  end

  // The string state clears after the final byte of each string.
  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      pend_r     <= 2'd0;
      rule_r     <= RULE_NONE;
      cnt_r      <= '0;
      text_err_r <= 1'b0;
      name_err_r <= 1'b0;
      first_r    <= 1'b1;
    end else if (advance) begin
      pend_r     <= pend_nxt;
      rule_r     <= rule_nxt;
      cnt_r      <= cnt_nxt;
      text_err_r <= text_err_nxt;
      name_err_r <= name_err_nxt;
      first_r    <= first_nxt;
    end
  end

endmodule

// ----- src/utf8iv_out_stage.sv -----
// ----------------------------------------------------------------------------
// utf8iv_out_stage
// Result register holding one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8iv_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_load,
  input  utf8iv_pkg::result_t  res,
  output logic                 res_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output utf8iv_pkg::result_t  out_res
);
  import utf8iv_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (res_load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- src/utf8_identifier_validator_top.sv -----
// ----------------------------------------------------------------------------
// utf8_identifier_validator_top
// Strict UTF-8 and identifier checker for byte-serial strings.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, back to back, with no bubbles between strings,
// unless the input stalls. A byte is registered at the input, then checked
// against the per-string state, and on the final byte the verdict lands in
// the result register, so a result passes the input register and then the
// result register. Non-final bytes produce no result. The input stalls only
// while a finished result waits in the result register and another final
// byte is ready to go. There is no clearing pass after reset. The length limit
// register may be rewritten only while no string is in flight.
module utf8_identifier_validator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_string_valid,
  output logic        out_identifier_valid,
  output logic [15:0] out_byte_count
);
  import utf8iv_pkg::*;

  item_t   in_item, item;
  logic    item_valid, advance, res_load, res_free;
  result_t res, out_res;

  assign in_item.byte_value = in_byte_value;
  assign in_item.last_byte  = in_last_byte;

  // A final byte waits only for room in the result register.
  assign advance = item_valid && (!item.last_byte || res_free);

  utf8iv_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  utf8iv_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .res_load    (res_load),
    .res         (res)
  );

  utf8iv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_string_valid     = out_res.string_valid;
  assign out_identifier_valid = out_res.identifier_valid;
  assign out_byte_count       = out_res.byte_count;

endmodule

// ----- src/utf8iv_checker.sv -----
// ----------------------------------------------------------------------------
// utf8iv_checker
// Port-level checks on the validator's result channel.
// ----------------------------------------------------------------------------
module utf8iv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_string_valid,
  input logic        out_identifier_valid,
  input logic [15:0] out_byte_count
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_string_valid) &&
      $stable(out_identifier_valid) && $stable(out_byte_count))
    else $error("stalled result changed");

  // An identifier verdict implies a valid string.
  a_id_implies_str: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_identifier_valid |-> out_string_valid)
    else $error("identifier valid without string valid");

  // Identifiers are limited to 255 bytes.
  a_id_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_identifier_valid |-> out_byte_count <= 16'd255)
    else $error("identifier longer than 255 bytes");

  // Every string holds at least its final byte.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_count != 16'd0)
    else $error("result with zero byte count");

endmodule

bind utf8_identifier_validator_top utf8iv_checker u_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_string_valid     (out_string_valid),
  .out_identifier_valid (out_identifier_valid),
  .out_byte_count       (out_byte_count)
);

// ----- tb/utf8_identifier_validator_top_test.sv -----
// ----------------------------------------------------------------------------
// utf8_identifier_validator_top_test
// Self-checking bench for the byte-serial UTF-8 and identifier checker.
// ----------------------------------------------------------------------------
// Walks a short table of hand-picked strings, then sweeps the length limit
// through its extremes, and then sends random strings (mostly well-formed,
// some corrupted) under several idle and stall mixes. Every verdict is checked,
// field by field and in order, against its given value or a bench model of the string state.
// ----------------------------------------------------------------------------
module utf8_identifier_validator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8iv_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int HoldCycles = 200;

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [31:0] seq;
    logic [2:0]  n;
    logic        typed;
    result_t     want;
  } dir_row_t;

  typedef struct {
    bit      typed;
    result_t want;
  } verdict_note_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_string_valid;
  logic        out_identifier_valid;
  logic [15:0] out_byte_count;

  // Bench copy of the checker state.
  logic [15:0]          limit_bytes = MaxBytesReset;
  logic [1:0]           cont_left = '0;
  rule_t                next_rule = RULE_NONE;
  logic [CountBits-1:0] str_len = '0;
  logic                 text_bad = 1'b0;
  logic                 name_bad = 1'b0;
  logic                 first_code = 1'b1;

  result_t       verdicts_due[$];
  verdict_note_t typed_verdicts[$];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_granted = 0;
  int hold_left = 0;

  dir_row_t dir_rows[14] = '{
    '{32'h4100_0000, 3'd1, 1'b1, '{1'b1, 1'b1, 16'd1}},
    '{32'h0000_0000, 3'd1, 1'b1, '{1'b0, 1'b0, 16'd1}},
    '{32'hFF00_0000, 3'd1, 1'b1, '{1'b0, 1'b0, 16'd1}},
    '{32'h8000_0000, 3'd1, 1'b1, '{1'b0, 1'b0, 16'd1}},
    '{32'h7F00_0000, 3'd1, 1'b1, '{1'b1, 1'b0, 16'd1}},
    '{32'h5F39_0000, 3'd2, 1'b1, '{1'b1, 1'b1, 16'd2}},
    '{32'hC280_0000, 3'd2, 1'b0, '{1'b0, 1'b0, 16'd0}},
    '{32'hE09F_8000, 3'd3, 1'b1, '{1'b0, 1'b0, 16'd3}},
    '{32'hEDA0_8000, 3'd3, 1'b1, '{1'b0, 1'b0, 16'd3}},
    '{32'hF490_8080, 3'd4, 1'b1, '{1'b0, 1'b0, 16'd4}},
    '{32'hF090_8080, 3'd4, 1'b0, '{1'b0, 1'b0, 16'd0}},
    '{32'hE200_0000, 3'd1, 1'b1, '{1'b0, 1'b0, 16'd1}},
    '{32'hC341_0000, 3'd2, 1'b1, '{1'b0, 1'b0, 16'd2}},
    '{32'h0061_0000, 3'd2, 1'b1, '{1'b0, 1'b0, 16'd2}}
  };

  logic [15:0] phase_limit[4] = '{16'd4096, 16'd5, 16'd65535, 16'd12};
  int          phase_idle[4]  = '{0, 64, 0, 27};
  int          phase_stall[4] = '{0, 0, 64, 27};

  utf8_identifier_validator_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte_value        (in_byte_value),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_string_valid     (out_string_valid),
    .out_identifier_valid (out_identifier_valid),
    .out_byte_count       (out_byte_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("utf8_identifier_validator_top_test: done, errors");
      $finish;
    end
  end

  // Advances the string state by one byte; returns 1 with the verdict on a
  // final byte.
  function automatic bit judge_byte(input logic [7:0] b, input logic last,
                                    output result_t verdict);
    logic letter;
    logic digit;
    logic str_ok;
    verdict = '0;
    letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
    digit = b >= 8'h30 && b <= 8'h39;
    if (str_len != CountMax) str_len++;
    if (cont_left == 2'd0) begin
      if (b <= 8'h7F) begin
        if (b == 8'h00) text_bad = 1'b1;
        if (!(letter || (!first_code && digit))) name_bad = 1'b1;
      end else if (b >= LeadTwoLo && b <= LeadTwoHi) begin
        cont_left = 2'd1;
        next_rule = RULE_NONE;
      end else if (b >= LeadThreeLo && b <= LeadThreeHi) begin
        cont_left = 2'd2;
        next_rule = (b == LeadThreeLo) ? RULE_GE_A0 :
                    (b == LeadSurr) ? RULE_LT_A0 : RULE_NONE;
      end else if (b >= LeadFourLo && b <= LeadFourHi) begin
        cont_left = 2'd3;
        next_rule = (b == LeadFourLo) ? RULE_GE_90 :
                    (b == LeadFourHi) ? RULE_LT_90 : RULE_NONE;
      end else begin
        text_bad = 1'b1;
      end
      first_code = 1'b0;
    end else if ((b & ContMask) != ContTag) begin
      // A missing continuation drops the sequence; the byte is not a new lead.
      text_bad = 1'b1;
      cont_left = 2'd0;
      next_rule = RULE_NONE;
    end else begin
      case (next_rule)
        RULE_GE_A0: if (b < ContA0) text_bad = 1'b1;
        RULE_LT_A0: if (b >= ContA0) text_bad = 1'b1;
        RULE_GE_90: if (b < Cont90) text_bad = 1'b1;
        RULE_LT_90: if (b >= Cont90) text_bad = 1'b1;
        default: ;
      endcase
      next_rule = RULE_NONE;
      cont_left = cont_left - 2'd1;
    end
    if (!last) return 1'b0;
    str_ok = !text_bad && cont_left == 2'd0 && str_len >= 1 && str_len <= limit_bytes;
    verdict.string_valid = str_ok;
    verdict.identifier_valid = str_ok && !name_bad && 32'(str_len) <= NameMaxBytes;
    verdict.byte_count = (32'(str_len) > ShowMax) ? 16'hFFFF : 16'(str_len);
    cont_left = 2'd0;
    next_rule = RULE_NONE;
    str_len = '0;
    text_bad = 1'b0;
    name_bad = 1'b0;
    first_code = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    result_t       verdict;
    result_t       w;
    verdict_note_t note;
    if (rst_n && in_valid && !in_stall) begin
      if (judge_byte(in_byte_value, in_last_byte, verdict)) begin
        note = typed_verdicts.pop_front();
        verdicts_due.push_back(note.typed ? note.want : verdict);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with no request pending: sv=%0b id=%0b count=%0d", $time,
                 out_string_valid, out_identifier_valid, out_byte_count);
        errors++;
      end else begin
        w = verdicts_due.pop_front();
        if (out_string_valid !== w.string_valid) begin
          $display("%0t: string_valid expected %0b got %0b", $time,
                   w.string_valid, out_string_valid);
          errors++;
        end
        if (out_identifier_valid !== w.identifier_valid) begin
          $display("%0t: identifier_valid expected %0b got %0b", $time,
                   w.identifier_valid, out_identifier_valid);
          errors++;
        end
        if (out_byte_count !== w.byte_count) begin
          $display("%0t: byte_count expected %0d got %0d", $time,
                   w.byte_count, out_byte_count);
          errors++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_granted != hold_asked) begin
      hold_left = HoldCycles;
      hold_granted = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_string(input octets_t s, input bit typed, input result_t want);
    typed_verdicts.push_back('{typed, want});
    for (int k = 0; k < s.size(); k++) send_byte(s[k], k == s.size() - 1);
  endtask

  task automatic send_run(input int n, input result_t want);
    octets_t s;
    repeat (n) s.push_back(8'h61);
    send_string(s, 1'b1, want);
  endtask

  // Lets the watcher catch up first, so a request taken at this step is already predicted.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_bytes = v;
  endtask

  // Mostly well-formed code points with random content; a quarter get broken.
  function automatic octets_t random_string();
    octets_t s;
    logic [7:0] lead;
    int idx;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          case ($urandom_range(0, 3))
            0: s.push_back(8'h41 + 8'($urandom_range(0, 25)));
            1: s.push_back(8'h61 + 8'($urandom_range(0, 25)));
            2: s.push_back(8'h30 + 8'($urandom_range(0, 9)));
            default: s.push_back(8'h5F);
          endcase
        end
        3: s.push_back(8'($urandom_range(1, 127)));
        4, 5: begin
          s.push_back(8'($urandom_range(LeadTwoLo, LeadTwoHi)));
          s.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        6, 7: begin
          case ($urandom_range(0, 3))
            0: lead = LeadThreeLo;
            1: lead = LeadSurr;
            default: lead = 8'($urandom_range(LeadThreeLo, LeadThreeHi));
          endcase
          s.push_back(lead);
          if (lead == LeadThreeLo) s.push_back(8'($urandom_range(ContA0, 8'hBF)));
          else if (lead == LeadSurr) s.push_back(8'($urandom_range(8'h80, 8'h9F)));
          else s.push_back(8'($urandom_range(8'h80, 8'hBF)));
          s.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: lead = LeadFourLo;
            1: lead = LeadFourHi;
            default: lead = 8'($urandom_range(LeadFourLo, LeadFourHi));
          endcase
          s.push_back(lead);
          if (lead == LeadFourLo) s.push_back(8'($urandom_range(Cont90, 8'hBF)));
          else if (lead == LeadFourHi) s.push_back(8'($urandom_range(8'h80, 8'h8F)));
          else s.push_back(8'($urandom_range(8'h80, 8'hBF)));
          repeat (2) s.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
    end
    if ($urandom_range(0, 99) < 25) begin
      idx = $urandom_range(0, s.size() - 1);
      case ($urandom_range(0, 2))
        0: s[idx] = 8'($urandom_range(0, 255));
        1: if (s.size() > 1) void'(s.pop_back());
        default: s.insert(idx, 8'($urandom_range(0, 255)));
      endcase
    end
    return s;
  endfunction

  initial begin
    octets_t s;
    int sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      s.delete();
      for (int k = 0; k < dir_rows[i].n; k++) s.push_back(dir_rows[i].seq[31 - 8 * k -: 8]);
      send_string(s, dir_rows[i].typed, dir_rows[i].want);
    end

    // Length limit at its extremes; a zero limit rejects every string.
    set_limit(16'd0);
    send_run(1, '{1'b0, 1'b0, 16'd1});
    set_limit(16'd1);
    send_run(1, '{1'b1, 1'b1, 16'd1});
    send_run(2, '{1'b0, 1'b0, 16'd2});
    set_limit(16'd3);
    send_run(3, '{1'b1, 1'b1, 16'd3});
    send_run(4, '{1'b0, 1'b0, 16'd4});
    set_limit(16'hFFFF);
    send_run(2, '{1'b1, 1'b1, 16'd2});

    for (int ph = 0; ph < 4; ph++) begin
      set_limit(phase_limit[ph]);
      idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph == 3) hold_asked++;
      sent = 0;
      while (sent < 90) begin
        s = random_string();
        send_string(s, 1'b0, '0);
        sent += s.size();
      end
    end

    wait_drain();
    if (errors == 0) begin
      $display("utf8_identifier_validator_top_test: done, clean");
    end else begin
      $display("utf8_identifier_validator_top_test: done, errors");
    end
    $finish;
  end

endmodule
